[rtl/gtj_pkg.sv]
// Shared constants and month tables for the Gregorian to Jalali date converter.
package gtj_pkg;

	localparam int unsigned GREG_BASE_YEAR   = 1600;
	localparam int unsigned GREG_MAX_YEAR    = 3199;
	localparam int unsigned FARVARDIN_OFFSET = 79;
	localparam int unsigned JAL_BASE_YEAR    = 979;
	localparam int unsigned DAYS_33Y         = 12053;
	localparam int unsigned DAYS_4Y          = 1461;
	localparam int unsigned DAYS_1Y          = 365;
	localparam int unsigned YEARS_PER_CYCLE  = 33;
	localparam int unsigned CENTURY          = 100;

	// reciprocal constants: floor(x / D) == (x * RECIP) >> SHIFT over the operand range
	localparam int unsigned SHIFT_100 = 17;
	localparam longint unsigned RECIP_100 = ((64'd1 << SHIFT_100) + CENTURY - 1) / CENTURY;
	localparam int unsigned SHIFT_33Y = 34;
	localparam longint unsigned RECIP_33Y = ((64'd1 << SHIFT_33Y) + DAYS_33Y - 1) / DAYS_33Y;
	localparam int unsigned SHIFT_4Y = 24;
	localparam longint unsigned RECIP_4Y = ((64'd1 << SHIFT_4Y) + DAYS_4Y - 1) / DAYS_4Y;

	// days in the Gregorian year before the first of the month (common year)
	function automatic logic [8:0] greg_days_before(input logic [3:0] month);
		logic [8:0] d;
		case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// day of the Jalali year on which month index m (0 is Farvardin) starts
	function automatic logic [8:0] jal_month_start(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd62;
			4'd3:    d = 9'd93;
			4'd4:    d = 9'd124;
			4'd5:    d = 9'd155;
			4'd6:    d = 9'd186;
			4'd7:    d = 9'd216;
			4'd8:    d = 9'd246;
			4'd9:    d = 9'd276;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd336;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

[rtl/gregorian_to_jalali_date_top.sv]
// Gregorian to Jalali date converter, nine-stage pipeline.
//
//  channel | handshake      | payload
//  --------+----------------+-------------------------------------------------------
//  input   | start / busy   | greg_year, greg_month, greg_day
//  result  | done (strobe)  | jal_year, jal_month, jal_day, day_number, out_of_range
//
// One item per cycle; each result appears on done once it has passed the stage registers S1 through S9.
// Stages: day count from 1600 (S1-S2), offset and range check (S3), 33-year split (S4-S5),
// 4-year split (S6-S7), year within the 4-year cycle (S8), month walk (S9).
// busy is always low: nothing downstream can hold a result, so the pipe never stalls.
// arst_n clears the valid bits only; data registers are not reset.
module gregorian_to_jalali_date_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] greg_year,
	input  logic [3:0]  greg_month,
	input  logic [4:0]  greg_day,
	output logic        done,
	output logic [11:0] jal_year,
	output logic [3:0]  jal_month,
	output logic [4:0]  jal_day,
	output logic [19:0] day_number,
	output logic        out_of_range
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// S1
	logic        bad_s1;
	logic [10:0] y_s1;
	logic [19:0] yr365_s1;
	logic [9:0]  c4_s1;
	logic [4:0]  n100_s1;
	logic [2:0]  n400_s1;
	logic [4:0]  q100_s1;
	logic [8:0]  cum_s1;
	logic        late_s1;
	logic [4:0]  dm1_s1;
	// S2
	logic        bad_s2;
	logic [19:0] days_s2;
	// S3
	logic        oor_s3;
	logic [19:0] jdn_s3;
	// S4
	logic        oor_s4;
	logic [19:0] jdn_s4;
	logic [5:0]  q33_s4;
	// S5
	logic        oor_s5;
	logic [19:0] jdn_s5;
	logic [13:0] rem33_s5;
	logic [11:0] jy_s5;
	// S6
	logic        oor_s6;
	logic [19:0] jdn_s6;
	logic [13:0] rem33_s6;
	logic [11:0] jy_s6;
	logic [3:0]  q4_s6;
	// S7
	logic        oor_s7;
	logic [19:0] jdn_s7;
	logic [10:0] rem4_s7;
	logic [11:0] jy_s7;
	// S8
	logic        oor_s8;
	logic [19:0] jdn_s8;
	logic [8:0]  ryear_s8;
	logic [11:0] jy_s8;
	// S9
	logic        oor_s9;
	logic [19:0] jdn_s9;
	logic [11:0] jy_s9;
	logic [3:0]  jm_s9;
	logic [4:0]  jd_s9;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// ---- S1: year offset, leap-day counts via reciprocal multiply
	logic [10:0] y_c;
	logic [11:0] y99_c, y399_c;
	logic [9:0]  y399d4_c;
	logic [21:0] pq100_c, pn100_c, pn400_c;
	logic        bad_c;

	always_comb begin
		y_c      = 11'(greg_year - 12'(gtj_pkg::GREG_BASE_YEAR));
		y99_c    = 12'(y_c) + 12'd99;
		y399_c   = 12'(y_c) + 12'd399;
		y399d4_c = y399_c[11:2];
		pq100_c  = 22'(y_c) * 22'(gtj_pkg::RECIP_100);
		pn100_c  = 22'(y99_c) * 22'(gtj_pkg::RECIP_100);
		pn400_c  = 22'(y399d4_c) * 22'(gtj_pkg::RECIP_100);
		bad_c    = (greg_year < 12'(gtj_pkg::GREG_BASE_YEAR))
			|| (greg_year > 12'(gtj_pkg::GREG_MAX_YEAR))
			|| (greg_month == 4'd0) || (greg_month > 4'd12) || (greg_day == 5'd0);
	end

	always_ff @(posedge clk) begin
		bad_s1   <= bad_c;
		y_s1     <= y_c;
		yr365_s1 <= 20'(y_c) * 20'(gtj_pkg::DAYS_1Y);
		c4_s1    <= 10'((12'(y_c) + 12'd3) >> 2);
		q100_s1  <= pq100_c[gtj_pkg::SHIFT_100 +: 5];
		n100_s1  <= pn100_c[gtj_pkg::SHIFT_100 +: 5];
		n400_s1  <= pn400_c[gtj_pkg::SHIFT_100 +: 3];
		cum_s1   <= gtj_pkg::greg_days_before(greg_month);
		late_s1  <= greg_month > 4'd2;
		dm1_s1   <= greg_day - 5'd1;
	end

	// ---- S2: days since 1600-01-01
	logic        leap_c;
	logic [20:0] days_c;

	always_comb begin
		leap_c = (y_s1[1:0] == 2'd0)
			&& ((y_s1 != 11'(q100_s1 * 11'(gtj_pkg::CENTURY))) || (q100_s1[1:0] == 2'd0));
		days_c = 21'(yr365_s1) + 21'(c4_s1) - 21'(n100_s1) + 21'(n400_s1)
			+ 21'(cum_s1) + 21'(late_s1 && leap_c) + 21'(dm1_s1);
	end

	always_ff @(posedge clk) begin
		bad_s2  <= bad_s1;
		days_s2 <= days_c[19:0];
	end

	// ---- S3: shift origin to Farvardin 1, 979
	always_ff @(posedge clk) begin
		oor_s3 <= bad_s2 || (days_s2 < 20'(gtj_pkg::FARVARDIN_OFFSET));
		jdn_s3 <= days_s2 - 20'(gtj_pkg::FARVARDIN_OFFSET);
	end

	// ---- S4: count of 33-year cycles
	logic [40:0] p33_c;
	assign p33_c = 41'(jdn_s3) * 41'(gtj_pkg::RECIP_33Y);

	always_ff @(posedge clk) begin
		oor_s4 <= oor_s3;
		jdn_s4 <= jdn_s3;
		q33_s4 <= p33_c[gtj_pkg::SHIFT_33Y +: 6];
	end

	// ---- S5: remainder within the 33-year cycle
	always_ff @(posedge clk) begin
		oor_s5   <= oor_s4;
		jdn_s5   <= jdn_s4;
		rem33_s5 <= 14'(jdn_s4 - 20'(q33_s4) * 20'(gtj_pkg::DAYS_33Y));
		jy_s5    <= 12'(gtj_pkg::JAL_BASE_YEAR) + 12'(q33_s4) * 12'(gtj_pkg::YEARS_PER_CYCLE);
	end

	// ---- S6: count of 4-year cycles
	logic [27:0] p4_c;
	assign p4_c = 28'(rem33_s5) * 28'(gtj_pkg::RECIP_4Y);

	always_ff @(posedge clk) begin
		oor_s6   <= oor_s5;
		jdn_s6   <= jdn_s5;
		rem33_s6 <= rem33_s5;
		jy_s6    <= jy_s5;
		q4_s6    <= p4_c[gtj_pkg::SHIFT_4Y +: 4];
	end

	// ---- S7: remainder within the 4-year cycle
	always_ff @(posedge clk) begin
		oor_s7  <= oor_s6;
		jdn_s7  <= jdn_s6;
		rem4_s7 <= 11'(rem33_s6 - 14'(q4_s6) * 14'(gtj_pkg::DAYS_4Y));
		jy_s7   <= jy_s6 + {6'd0, q4_s6, 2'b00};
	end

	// ---- S8: year within the 4-year cycle; first year has 366 days
	logic [1:0]  q1_c;
	logic [10:0] r_c;

	always_comb begin
		if (rem4_s7 < 11'd366) begin
			q1_c = 2'd0;
			r_c  = rem4_s7;
		end else if (rem4_s7 < 11'd731) begin
			q1_c = 2'd1;
			r_c  = rem4_s7 - 11'd366;
		end else if (rem4_s7 < 11'd1096) begin
			q1_c = 2'd2;
			r_c  = rem4_s7 - 11'd731;
		end else begin
			q1_c = 2'd3;
			r_c  = rem4_s7 - 11'd1096;
		end
	end

	always_ff @(posedge clk) begin
		oor_s8   <= oor_s7;
		jdn_s8   <= jdn_s7;
		ryear_s8 <= r_c[8:0];
		jy_s8    <= jy_s7 + 12'(q1_c);
	end

	// ---- S9: month walk; the last month absorbs the rest of the year
	logic [3:0] jm_c;
	logic [8:0] dom_c;

	always_comb begin
		jm_c = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (ryear_s8 >= gtj_pkg::jal_month_start(4'(i)))
				jm_c = jm_c + 4'd1;
		end
		dom_c = ryear_s8 - gtj_pkg::jal_month_start(jm_c);
	end

	always_ff @(posedge clk) begin
		oor_s9 <= oor_s8;
		jdn_s9 <= oor_s8 ? 20'd0 : jdn_s8;
		jy_s9  <= oor_s8 ? 12'd0 : jy_s8;
		jm_s9  <= oor_s8 ? 4'd0  : jm_c + 4'd1;
		jd_s9  <= oor_s8 ? 5'd0  : 5'(dom_c) + 5'd1;
	end

	assign done         = v_s9;
	assign jal_year     = jy_s9;
	assign jal_month    = jm_s9;
	assign jal_day      = jd_s9;
	assign day_number   = jdn_s9;
	assign out_of_range = oor_s9;

endmodule
